/* hw/rtl/turn_indicator_flasher_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the turn indicator flasher.
// ---------------------------------------------------------------------------
`ifndef TURN_INDICATOR_FLASHER_MACROS_SVH
`define TURN_INDICATOR_FLASHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TIF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tif_pkg.sv */
// ---------------------------------------------------------------------------
// tif_pkg
// Types, constants and the per-side update function of the flasher.
// ---------------------------------------------------------------------------
package tif_pkg;

  typedef enum logic [1:0] {
    CMD_LAMP_REQ    = 2'd0,
    CMD_BLINK_START = 2'd1,
    CMD_BLINK_TICK  = 2'd2,
    CMD_OFF_TICK    = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_BLINK_PERIOD = 1'b0,
    CFG_BLINK_PAIRS  = 1'b1
  } cfg_index_t;

  localparam logic [15:0] TTC_NONE          = 16'd200;
  localparam logic [4:0]  OFF_LIMIT_MAX     = 5'd30;
  localparam logic [4:0]  OFF_LIMIT_MIN     = 5'd10;
  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd50;
  localparam logic [6:0]  BLINK_PAIRS_RST   = 7'd3;

  typedef struct packed {
    logic        lamp_on;
    logic        blink_active;
    logic [7:0]  toggle_count;
    logic [16:0] blink_divider;
    logic        off_armed;
    logic [4:0]  off_counter;
    logic [4:0]  off_limit;
  } side_state_t;

  localparam side_state_t SIDE_RESET = '{
    lamp_on:       1'b0,
    blink_active:  1'b0,
    toggle_count:  8'd0,
    blink_divider: 17'd0,
    off_armed:     1'b0,
    off_counter:   5'd0,
    off_limit:     OFF_LIMIT_MAX
  };

  // State of one side after one event. 'hit' is high when the event names
  // this side; the off tick acts on both sides regardless.
  function automatic side_state_t side_next(
    input side_state_t cur,
    input cmd_t        cmd,
    input logic        hit,
    input logic        onoff,
    input logic [15:0] ttc,
    input logic [15:0] period,
    input logic [6:0]  pairs
  );
    side_state_t nxt;
    nxt = cur;
    case (cmd)
      CMD_LAMP_REQ: begin
        if (hit && !cur.blink_active) begin
          if (onoff) begin
            nxt.off_armed   = 1'b0;
            nxt.off_counter = 5'd0;
            nxt.lamp_on     = 1'b1;
            if (ttc != TTC_NONE && ttc < {11'd0, cur.off_limit}) begin
              nxt.off_limit = (ttc < {11'd0, OFF_LIMIT_MIN}) ? OFF_LIMIT_MIN : ttc[4:0];
            end
          end else begin
            nxt.off_armed = 1'b1;
          end
        end
      end
      CMD_BLINK_START: begin
        if (hit && onoff && !cur.blink_active) begin
          nxt.blink_active  = 1'b1;
          nxt.toggle_count  = 8'd0;
          nxt.blink_divider = 17'd0;
        end
      end
      CMD_BLINK_TICK: begin
        if (hit && cur.blink_active) begin
          if (cur.blink_divider > {1'b0, period}) begin
            if (cur.toggle_count < {pairs, 1'b0}) begin
              nxt.lamp_on      = ~cur.lamp_on;
              nxt.toggle_count = cur.toggle_count + 8'd1;
            end else begin
              nxt.lamp_on      = 1'b0;
              nxt.blink_active = 1'b0;
            end
            nxt.blink_divider = 17'd0;
          end else begin
            nxt.blink_divider = cur.blink_divider + 17'd1;
          end
        end
      end
      CMD_OFF_TICK: begin
        if (cur.off_armed) begin
          if (cur.off_counter > cur.off_limit) begin
            nxt.lamp_on     = 1'b0;
            nxt.off_counter = 5'd0;
            nxt.off_armed   = 1'b0;
            nxt.off_limit   = OFF_LIMIT_MAX;
          end else begin
            nxt.off_counter = cur.off_counter + 5'd1;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    return nxt;
  endfunction

endpackage

/* hw/rtl/turn_indicator_flasher.sv */
// ---------------------------------------------------------------------------
// turn_indicator_flasher
// Left/right turn indicator lamp controller with blink bursts and
// delayed lamp-off.
// ---------------------------------------------------------------------------
// The block takes one event beat per clock cycle while status beats are taken
// and returns a status beat in the cycle after each one. Each event is a lamp
// request, a blink start, a blink tick for one side or an off-delay tick for
// both sides; the status beat shows both lamps, both blink bursts and both
// pending delayed offs as they stand after that event. The only storage on
// the path is the per-side state register and the status output register,
// so the sustained rate is one event per cycle as long as the status beats
// are taken; a stalled status beat holds the input back only once the
// output register is full. Configuration writes take effect at once and are
// meant to be made while no event is in flight.
// ---------------------------------------------------------------------------
`include "turn_indicator_flasher_macros.svh"

module turn_indicator_flasher
  import tif_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [0] onoff, [16:1] ttc, rest zero
  input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] side
  // Status stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] left_lamp, [1] right_lamp,
                                      // [2] left_blinking, [3] right_blinking,
                                      // [4] left_off_pending,
                                      // [5] right_off_pending, rest zero
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] blink_period;
  logic [6:0]  blink_pairs;

  // Per-side state: index 0 is left, index 1 is right.
  side_state_t side_state [2];
  side_state_t side_state_next [2];

  logic        out_valid;
  logic [5:0]  out_status;

  logic        in_beat;
  cmd_t        ev_cmd;
  logic        ev_side;
  logic        ev_onoff;
  logic [15:0] ev_ttc;

  assign ev_cmd   = cmd_t'(s_axis_tuser[1:0]);
  assign ev_side  = s_axis_tuser[2];
  assign ev_onoff = s_axis_tdata[0];
  assign ev_ttc   = s_axis_tdata[16:1];

  // The output register frees up when its beat is taken, so a new event is
  // accepted in the same cycle that the previous status leaves.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= BLINK_PERIOD_RST;
      blink_pairs  <= BLINK_PAIRS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_PERIOD: blink_period <= cfg_data;
        CFG_BLINK_PAIRS:  blink_pairs  <= cfg_data[6:0];
        default:          blink_period <= blink_period;
      endcase
    end
  end

  // Both sides are updated in parallel; only the named side reacts to lamp
  // requests and blink commands, while the off tick reaches both.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      side_state_next[s] = side_next(side_state[s], ev_cmd, ev_side == s[0], ev_onoff,
                                     ev_ttc, blink_period, blink_pairs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_state[0] <= SIDE_RESET;
      side_state[1] <= SIDE_RESET;
    end else if (in_beat) begin
      side_state[0] <= side_state_next[0];
      side_state[1] <= side_state_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // The status payload is captured from the next-state values so it shows
  // the sides exactly as the event left them.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_status <= {side_state_next[1].off_armed, side_state_next[0].off_armed,
                     side_state_next[1].blink_active, side_state_next[0].blink_active,
                     side_state_next[1].lamp_on, side_state_next[0].lamp_on};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status};

  // An accepted event always leaves a status beat waiting.
  `TIF_ASSERT_NEXT(a_beat_follows, in_beat, m_axis_tvalid, "no status after event")

  // The status beat mirrors the state the event left behind.
  `TIF_ASSERT_NEXT(a_status_matches, in_beat,
    m_axis_tdata[0] == side_state[0].lamp_on && m_axis_tdata[1] == side_state[1].lamp_on &&
    m_axis_tdata[4] == side_state[0].off_armed && m_axis_tdata[5] == side_state[1].off_armed,
    "status differs from side state")

  // The off delay of each side stays between the minimum and the maximum.
  `TIF_ASSERT_NOW(a_limit_range, 1'b1,
    side_state[0].off_limit >= OFF_LIMIT_MIN && side_state[0].off_limit <= OFF_LIMIT_MAX &&
    side_state[1].off_limit >= OFF_LIMIT_MIN && side_state[1].off_limit <= OFF_LIMIT_MAX,
    "off delay out of range")

  // A left burst can only begin on a blink start for the left side.
  `TIF_ASSERT_NEXT(a_burst_start, in_beat && !side_state[0].blink_active &&
    side_state_next[0].blink_active, $past(ev_cmd) == CMD_BLINK_START && $past(ev_side) == 1'b0,
    "left burst began without blink start")

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb: turn indicator flasher testbench
// Drives lamp requests, blink starts, blink ticks and off-delay ticks into
// the flasher, predicts the status beat for every accepted event and checks
// each returned status beat against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Per-side state kept by the predictor.
typedef struct {
  bit        lit;
  bit        blinking;
  bit [7:0]  toggles;
  bit [16:0] divider;
  bit        off_armed;
  bit [4:0]  off_count;
  bit [4:0]  off_limit;
} indicator_side_t;

// Status beat, left lamp in bit 0.
typedef struct packed {
  bit right_off_pending;
  bit left_off_pending;
  bit right_blinking;
  bit left_blinking;
  bit right_lamp;
  bit left_lamp;
} lamp_status_t;

class lamp_status_board;
  indicator_side_t sides[2];
  bit [15:0]       period;
  bit [6:0]        pairs;
  lamp_status_t    expected_status[$];
  int              errors;

  function new();
    period = tif_pkg::BLINK_PERIOD_RST;
    pairs  = tif_pkg::BLINK_PAIRS_RST;
    errors = 0;
    for (int s = 0; s < 2; s++) begin
      sides[s] = '{lit: 0, blinking: 0, toggles: 0, divider: 0,
                   off_armed: 0, off_count: 0, off_limit: tif_pkg::OFF_LIMIT_MAX};
    end
  endfunction

  function void write_reg(tif_pkg::cfg_index_t idx, bit [15:0] value);
    if (idx == tif_pkg::CFG_BLINK_PERIOD) begin
      period = value;
    end else begin
      pairs = value[6:0];
    end
  endfunction

  function int pending();
    return expected_status.size();
  endfunction

  // Advance the predicted state by one accepted event and queue the status.
  function void note_event(tif_pkg::cmd_t cmd, bit side, bit onoff, bit [15:0] ttc);
    lamp_status_t st;
    case (cmd)
      tif_pkg::CMD_LAMP_REQ: begin
        // Requests are dropped while the side is in a burst.
        if (!sides[side].blinking) begin
          if (onoff) begin
            sides[side].off_armed = 0;
            sides[side].off_count = 0;
            sides[side].lit       = 1;
            // A time to collision only ever shortens the off delay, and
            // never below the floor.
            if (ttc != tif_pkg::TTC_NONE && ttc < {11'd0, sides[side].off_limit}) begin
              sides[side].off_limit = (ttc < {11'd0, tif_pkg::OFF_LIMIT_MIN}) ?
                                      tif_pkg::OFF_LIMIT_MIN : ttc[4:0];
            end
          end else begin
            sides[side].off_armed = 1;
          end
        end
      end
      tif_pkg::CMD_BLINK_START: begin
        if (onoff && !sides[side].blinking) begin
          sides[side].blinking = 1;
          sides[side].toggles  = 0;
          sides[side].divider  = 0;
        end
      end
      tif_pkg::CMD_BLINK_TICK: begin
        if (sides[side].blinking) begin
          if (sides[side].divider > {1'b0, period}) begin
            if (sides[side].toggles < {pairs, 1'b0}) begin
              sides[side].lit     = !sides[side].lit;
              sides[side].toggles = sides[side].toggles + 8'd1;
            end else begin
              sides[side].lit      = 0;
              sides[side].blinking = 0;
            end
            sides[side].divider = 0;
          end else begin
            sides[side].divider = sides[side].divider + 17'd1;
          end
        end
      end
      default: begin
        // The off tick counts on both sides, bursts or not.
        for (int s = 0; s < 2; s++) begin
          if (sides[s].off_armed) begin
            if (sides[s].off_count > sides[s].off_limit) begin
              sides[s].lit       = 0;
              sides[s].off_count = 0;
              sides[s].off_armed = 0;
              sides[s].off_limit = tif_pkg::OFF_LIMIT_MAX;
            end else begin
              sides[s].off_count = sides[s].off_count + 5'd1;
            end
          end
        end
      end
    endcase
    st.left_lamp         = sides[0].lit;
    st.right_lamp        = sides[1].lit;
    st.left_blinking     = sides[0].blinking;
    st.right_blinking    = sides[1].blinking;
    st.left_off_pending  = sides[0].off_armed;
    st.right_off_pending = sides[1].off_armed;
    expected_status.push_back(st);
  endfunction

  function void compare_field(string what, logic expected, logic actual);
    if (actual !== expected) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, expected, actual);
    end
  endfunction

  function void check_status(logic [7:0] beat);
    lamp_status_t want;
    if (expected_status.size() == 0) begin
      errors++;
      $display("%0t: status beat with nothing expected, expected none, got %h", $time, beat);
      return;
    end
    want = expected_status.pop_front();
    compare_field("left_lamp", want.left_lamp, beat[0]);
    compare_field("right_lamp", want.right_lamp, beat[1]);
    compare_field("left_blinking", want.left_blinking, beat[2]);
    compare_field("right_blinking", want.right_blinking, beat[3]);
    compare_field("left_off_pending", want.left_off_pending, beat[4]);
    compare_field("right_off_pending", want.right_off_pending, beat[5]);
    compare_field("pad bit 6", 1'b0, beat[6]);
    compare_field("pad bit 7", 1'b0, beat[7]);
  endfunction
endclass

module tb;
  import tif_pkg::*;

  localparam logic LEFT    = 1'b0;
  localparam logic RIGHT   = 1'b1;
  localparam logic REQ_ON  = 1'b1;
  localparam logic REQ_OFF = 1'b0;
  // Cycles the receiver refuses status beats in one go, long enough for the
  // output register to fill and the event side to stall.
  localparam int   HOLD_OFF_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [0] onoff, [16:1] ttc, rest zero
  logic [2:0]  s_axis_tuser;   // [1:0] cmd, [2] side
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] left_lamp, [1] right_lamp,
                               // [2] left_blinking, [3] right_blinking,
                               // [4] left_off_pending, [5] right_off_pending
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // Percent of cycles in which each side idles; changed as the run goes on.
  int tx_idle_pct = 18;
  int rx_idle_pct = 58;
  // Long hold-offs asked for by the stimulus, and those the receiver has
  // already served.
  int hold_off_reqs = 0;
  int hold_offs_done = 0;
  // Events accepted so far; the random phases stop on this count.
  int events_sent = 0;

  lamp_status_board board = new();

  turn_indicator_flasher uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Backstop: a correct run finishes in a small fraction of this.
  initial begin
    #400000;
    $display("turn_indicator_flasher: mismatch");
    $finish;
  end

  // Status receiver. Ready changes only on the falling edge. A hold-off
  // request keeps ready low for a long stretch counted here, while the
  // event side keeps offering beats.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != hold_offs_done) begin
        hold_offs_done++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Every status beat taken at a rising edge is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      board.check_status(m_axis_tdata);
    end
  end

  // Offer one event beat, with random idle cycles ahead of it, and hand it
  // to the predictor at the edge where it is taken. Valid stays high into
  // the next call unless that call starts with an idle cycle.
  task automatic send_event(input cmd_t cmd, input logic side, input logic onoff,
                            input logic [15:0] ttc);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ttc, onoff};
    s_axis_tuser  <= {side, cmd};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    board.note_event(cmd, side, onoff, ttc);
    events_sent++;
  endtask

  // Stop offering events and wait until every predicted status has come
  // back. One result per event, so the block is idle afterwards.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // Time to collision: often the no-value code, often near the off-delay
  // range, otherwise anything in 16 bits.
  function automatic logic [15:0] pick_ttc();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      return TTC_NONE;
    end else if (roll < 55) begin
      return 16'($urandom_range(0, 35));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_noise();
    int   roll;
    cmd_t cmd;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      cmd = CMD_LAMP_REQ;
    end else if (roll < 40) begin
      cmd = CMD_BLINK_START;
    end else if (roll < 75) begin
      cmd = CMD_BLINK_TICK;
    end else begin
      cmd = CMD_OFF_TICK;
    end
    send_event(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_ttc());
  endtask

  // Random traffic. Most of it comes as sequences that get somewhere: a lamp
  // lit, then released, then a run of off ticks; or a burst started and fed
  // with blink ticks for its side. Stray events are mixed in throughout.
  // The last sequence may run past the count by a few tens of events.
  task automatic random_traffic(input int count);
    int   target;
    int   roll;
    int   run;
    logic side;
    target = events_sent + count;
    while (events_sent < target) begin
      roll = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      if (roll < 35) begin
        send_noise();
      end else if (roll < 68) begin
        send_event(CMD_LAMP_REQ, side, REQ_ON, pick_ttc());
        send_event(CMD_LAMP_REQ, side, REQ_OFF, pick_ttc());
        run = $urandom_range(8, 34);
        repeat (run) begin
          if ($urandom_range(0, 99) < 85) begin
            send_event(CMD_OFF_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       pick_ttc());
          end else begin
            send_noise();
          end
        end
      end else begin
        send_event(CMD_BLINK_START, side, REQ_ON, pick_ttc());
        run = $urandom_range(4, 24);
        repeat (run) begin
          if ($urandom_range(0, 99) < 85) begin
            send_event(CMD_BLINK_TICK, side, 1'($urandom_range(0, 1)), pick_ttc());
          end else begin
            send_noise();
          end
        end
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BLINK_PERIOD;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Shortest divider and no flashes: a burst ends on its
    // first divider expiry without toggling the lamp.
    write_reg(CFG_BLINK_PERIOD, 16'd0);
    write_reg(CFG_BLINK_PAIRS, 16'd0);
    send_event(CMD_LAMP_REQ, LEFT, REQ_ON, TTC_NONE);
    send_event(CMD_BLINK_START, LEFT, REQ_OFF, 16'hffff);  // start without onoff
    send_event(CMD_BLINK_START, LEFT, REQ_ON, 16'h0000);
    send_event(CMD_LAMP_REQ, LEFT, REQ_ON, 16'd5);         // dropped, side is blinking
    send_event(CMD_BLINK_TICK, LEFT, REQ_OFF, 16'd0);
    send_event(CMD_BLINK_TICK, LEFT, REQ_OFF, 16'd0);      // burst ends here
    send_event(CMD_BLINK_TICK, RIGHT, REQ_ON, 16'd0);      // idle side, ignored
    drain();

    // One flash per burst on the right, with a short delayed off armed
    // before the burst: it stays armed through the burst and expires on the
    // off ticks that follow.
    write_reg(CFG_BLINK_PAIRS, 16'd1);
    send_event(CMD_LAMP_REQ, RIGHT, REQ_ON, 16'd5);        // delay clamped to the floor
    send_event(CMD_LAMP_REQ, RIGHT, REQ_ON, 16'hffff);     // longer value, no effect
    send_event(CMD_LAMP_REQ, RIGHT, REQ_OFF, 16'd0);
    send_event(CMD_BLINK_START, RIGHT, REQ_ON, TTC_NONE);
    repeat (6) send_event(CMD_BLINK_TICK, RIGHT, REQ_ON, 16'd0);
    repeat (12) send_event(CMD_OFF_TICK, LEFT, REQ_ON, 16'hffff);
    drain();

    // Random phases. Sender idles lightly and receiver heavily first, with
    // one long receiver hold-off to back the block up.
    tx_idle_pct = 18;
    rx_idle_pct = 58;
    write_reg(CFG_BLINK_PERIOD, 16'd3);
    write_reg(CFG_BLINK_PAIRS, 16'd2);
    hold_off_reqs++;
    random_traffic(100);
    drain();

    // Now the other way round, with the largest burst length.
    tx_idle_pct = 58;
    rx_idle_pct = 18;
    write_reg(CFG_BLINK_PERIOD, 16'd1);
    write_reg(CFG_BLINK_PAIRS, 16'd127);
    random_traffic(85);
    drain();

    write_reg(CFG_BLINK_PERIOD, 16'd0);
    write_reg(CFG_BLINK_PAIRS, 16'd5);
    random_traffic(40);
    // Sender pauses here until every outstanding status has come back.
    drain();
    random_traffic(40);
    drain();

    // No idling at all. Longest divider: bursts never reach a toggle.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_BLINK_PERIOD, 16'hffff);
    write_reg(CFG_BLINK_PAIRS, 16'd0);
    random_traffic(30);
    drain();

    write_reg(CFG_BLINK_PERIOD, 16'd2);
    write_reg(CFG_BLINK_PAIRS, 16'd1);
    random_traffic(75);
    drain();

    // Give any stray beat a chance to show up before the verdict.
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("turn_indicator_flasher: match");
    end else begin
      $display("turn_indicator_flasher: mismatch");
    end
    $finish;
  end
endmodule
